// ===== sv/sida_pkg.sv =====
// Shared types, constants and helpers for the signed integer to decimal ASCII converter.
// No dependencies.
package sida_pkg;

    localparam int VALUE_W    = 32;
    localparam int N_DIGITS   = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = N_DIGITS * DIGIT_W;
    localparam int STEP_W     = $clog2(VALUE_W);
    localparam int CNT_W      = $clog2(N_DIGITS + 1);
    localparam int CHAR_W     = 6;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CODE_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CODE_MINUS = 6'd45;

    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_conv;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SIGN,
        B_DIGIT
    } t_back_state;

    // Add 3 to every BCD digit that is 5 or more, ahead of the shift.
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int i = 0; i < N_DIGITS; i++) begin
            if (b[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                r[i*DIGIT_W +: DIGIT_W] = b[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/sida_front.sv =====
// Front end: accepts a value, takes its magnitude and converts it to BCD by shift-add-3.
// Depends on sida_pkg.
module sida_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sida_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_full,
    output logic                                o_push,
    output sida_pkg::t_conv                     o_data
);
    import sida_pkg::*;

    t_front_state          r_state;
    t_front_state          n_state;
    logic [VALUE_W-1:0]    r_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic                  r_neg;
    logic [STEP_W-1:0]     r_step;
    logic [VALUE_W-1:0]    w_raw;
    logic                  w_accept;

    assign w_raw    = VALUE_W'(unsigned'(i_value));
    assign w_accept = start && !busy;
    assign busy     = (r_state != F_IDLE);
    assign o_data   = '{neg: r_neg, bcd: r_bcd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (start) begin
                    n_state = F_CONV;
                end
            end
            F_CONV: begin
                if (r_step == STEP_W'(VALUE_W - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg  <= w_raw[VALUE_W-1];
            // magnitude in unsigned arithmetic, so the most negative value stays exact
            r_mag  <= w_raw[VALUE_W-1] ? (~w_raw + 1'b1) : w_raw;
            r_bcd  <= '0;
            r_step <= '0;
        end else if (r_state == F_CONV) begin
            {r_bcd, r_mag} <= {bcd_adjust(r_bcd), r_mag} << 1;
            r_step         <= r_step + 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == F_CONV) && (r_step == '0))
        else $error("front did not start conversion after accept");
    a_push_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_state == F_IDLE) && !busy)
        else $error("front not idle after push");
`endif

endmodule

// ===== sv/sida_fifo.sv =====
// Short queue of converted BCD entries between the front and back ends.
// Depends on sida_pkg.
module sida_fifo #(
    parameter int DEPTH = sida_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sida_pkg::t_conv i_data,
    output logic            o_full,
    input  logic            i_pop,
    output sida_pkg::t_conv o_data,
    output logic            o_empty
);
    import sida_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_conv         r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;
    logic          w_wr_en;
    logic          w_rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr_en = i_push && !o_full;
    assign w_rd_en = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr_en && !w_rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd_en && !w_wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && !w_rd_en) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not track push");
`endif

endmodule

// ===== sv/sida_back.sv =====
// Back end: emits sign and digits of one queued entry, one character per cycle
// once leading zeros are skipped. Depends on sida_pkg.
module sida_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  sida_pkg::t_conv               i_data,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [sida_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import sida_pkg::*;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [BCD_W-1:0]     r_digits;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_lead;
    logic                 r_valid;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_last;
    logic [DIGIT_W-1:0]   w_top;
    logic                 w_final;
    logic                 w_emit;
    logic [CHAR_W-1:0]    w_char;
    logic                 w_last;

    assign w_top   = r_digits[BCD_W-1 -: DIGIT_W];
    assign w_final = (r_cnt == CNT_W'(1));

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_emit;
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_emit  = 1'b0;
        w_char  = CODE_ZERO + CHAR_W'(w_top);
        w_last  = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = i_data.neg ? B_SIGN : B_DIGIT;
                end
            end
            B_SIGN: begin
                w_emit  = 1'b1;
                w_char  = CODE_MINUS;
                n_state = B_DIGIT;
            end
            B_DIGIT: begin
                // leading zeros are dropped, but the units digit always goes out
                if (!(r_lead && (w_top == '0) && !w_final)) begin
                    w_emit = 1'b1;
                    w_last = w_final;
                    if (w_final) begin
                        n_state = B_IDLE;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_digits <= i_data.bcd;
            r_cnt    <= CNT_W'(N_DIGITS);
            r_lead   <= 1'b1;
        end else if (r_state == B_DIGIT) begin
            r_digits <= r_digits << DIGIT_W;
            r_cnt    <= r_cnt - 1'b1;
            if (w_emit) begin
                r_lead <= 1'b0;
            end
        end
        r_char <= w_char;
        r_last <= w_last;
    end

`ifndef SYNTHESIS
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_state == B_IDLE))
        else $error("last character while run still active");
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CODE_MINUS) ||
                    ((o_char_code >= CODE_ZERO) && (o_char_code <= CODE_ZERO + 6'd9)))
        else $error("character code out of range");
`endif

endmodule

// ===== sv/signed_int_to_decimal_ascii_top.sv =====
// Leading zeros are skipped before the first digit (after the sign, if negative); the
// remaining digits follow one per cycle, 1 to 11 characters per value.
// The front end accepts a new value only when idle; its 32-step shift-add-3 conversion
// and the push into the queue (which waits while the queue is full) must finish first.
// Reset (synchronous, active low) empties the queue and returns both ends to idle.
// The receiver cannot stall: each character is presented for one cycle with o_valid.
module signed_int_to_decimal_ascii_top #(
    parameter int FIFO_DEPTH = sida_pkg::FIFO_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sida_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    output logic [sida_pkg::CHAR_W-1:0]         o_char_code,
    output logic                                o_last
);
    import sida_pkg::*;

    t_conv w_push_data;
    t_conv w_pop_data;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;

    sida_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_value (i_value),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_data  (w_push_data)
    );

    sida_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_data),
        .o_empty (w_empty)
    );

    sida_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_data      (w_pop_data),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

endmodule
